// ===== rtl/core/page_allocator_with_refcount_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Page allocator assertion macros
// Shared property wrappers for the checker, clocked on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef PAGE_ALLOCATOR_WITH_REFCOUNT_UNIT_DEFINES_SVH
`define PAGE_ALLOCATOR_WITH_REFCOUNT_UNIT_DEFINES_SVH

// same-cycle implication
`define PGA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pga check failed");

// next-cycle implication
`define PGA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pga check failed");

`endif

// ===== rtl/core/pga_pkg.sv =====
// ----------------------------------------------------------------------------
// Page allocator package
// Field widths, command and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package pga_pkg;

  localparam int NUM_PAGES_DEF = 32768;
  localparam int REF_BITS_DEF  = 8;

  localparam int CMD_W    = 2;
  localparam int PAGE_W   = 15;
  localparam int FIRST_W  = 15;
  localparam int LIMIT_W  = 16;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 8;

  localparam int APB_DW  = 32;
  localparam int PADDR_W = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'h8000;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REF_INC = 2'd2,
    CMD_INIT    = 2'd3
  } command_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HELD  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

  localparam logic REG_FIRST_PAGE = 1'b0;
  localparam logic REG_LIMIT_PAGE = 1'b1;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic exec;
    logic init_rd;
    logic init_wr;
    logic init_done;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic init_more;
    logic out_free;
    logic in_init;
  } dp_stat_t;

endpackage

// ===== rtl/core/pga_ctrl.sv =====
// ----------------------------------------------------------------------------
// Page allocator controller
// Sequences the clearing pass, single-item commands and the init walk.
// ----------------------------------------------------------------------------
module pga_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output pga_pkg::dp_cmd_t   cmd,
  input  pga_pkg::dp_stat_t  stat
);
  import pga_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_INIT_RD,
    S_INIT_WR,
    S_INIT_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          if (stat.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= stat.in_init ? S_INIT_RD : S_EXEC;
        end
        S_EXEC: begin
          if (stat.out_free) state <= S_IDLE;
        end
        S_INIT_RD: begin
          state <= stat.init_more ? S_INIT_WR : S_INIT_DONE;
        end
        S_INIT_WR: begin
          state <= S_INIT_RD;
        end
        S_INIT_DONE: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.clr_step  = (state == S_CLEAR);
    cmd.accept    = (state == S_IDLE) && in_valid;
    cmd.exec      = (state == S_EXEC) && stat.out_free;
    cmd.init_rd   = (state == S_INIT_RD) && stat.init_more;
    cmd.init_wr   = (state == S_INIT_WR);
    cmd.init_done = (state == S_INIT_DONE) && stat.out_free;
  end

endmodule

// ===== rtl/core/pga_dpath.sv =====
// ----------------------------------------------------------------------------
// Page allocator datapath
// Free-page stack, reference count memory, depth and walk counters, result
// register.
// ----------------------------------------------------------------------------
module pga_dpath #(
  parameter int NUM_PAGES = pga_pkg::NUM_PAGES_DEF,
  parameter int REF_BITS  = pga_pkg::REF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pga_pkg::dp_cmd_t              cmd,
  output pga_pkg::dp_stat_t             stat,
  input  logic [pga_pkg::CMD_W-1:0]     command,
  input  logic [pga_pkg::PAGE_W-1:0]    page,
  input  logic [pga_pkg::FIRST_W-1:0]   first_page,
  input  logic [pga_pkg::LIMIT_W-1:0]   limit_page,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pga_pkg::STATUS_W-1:0]  status,
  output logic [pga_pkg::PAGE_W-1:0]    alloc_page,
  output logic [pga_pkg::CNT_W-1:0]     ref_count
);
  import pga_pkg::*;

  localparam int AW = $clog2(NUM_PAGES);
  localparam int DW = $clog2(NUM_PAGES + 1);
  localparam int SW = (DW > LIMIT_W) ? DW : LIMIT_W;
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  logic [PAGE_W-1:0]   stack_mem [NUM_PAGES];
  logic [REF_BITS-1:0] ref_mem   [NUM_PAGES];

  logic [PAGE_W-1:0]   stack_rd;
  logic [REF_BITS-1:0] ref_rd;

  logic                stack_we, stack_re, ref_we, ref_re;
  logic [AW-1:0]       stack_waddr, stack_raddr, ref_waddr, ref_raddr;
  logic [PAGE_W-1:0]   stack_wdata;
  logic [REF_BITS-1:0] ref_wdata;

  logic [DW-1:0]       depth, depth_next, depth_m1;
  logic [SW-1:0]       cur, hi;
  logic [CMD_W-1:0]    op_cmd;
  logic [PAGE_W-1:0]   op_page;
  logic                init_full;

  logic [STATUS_W-1:0] res_status;
  logic [PAGE_W-1:0]   res_page;
  logic [REF_BITS-1:0] res_cnt;
  logic                res_load;

  logic                full, op_in_pages, free_bad, alloc_in_pages;
  logic [REF_BITS-1:0] rel_dec, inc_cnt;
  logic                rel_held, rel_push;
  logic [STATUS_W-1:0] rel_status;
  logic [REF_BITS-1:0] rel_left;
  logic [AW-1:0]       op_idx, cur_idx;

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    if (stack_re) stack_rd <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk) begin
    if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
    if (ref_re) ref_rd <= ref_mem[ref_raddr];
  end

  assign depth_m1       = depth - DW'(1);
  assign full           = (depth == DW'(NUM_PAGES));
  assign op_in_pages    = (32'(op_page) < 32'(NUM_PAGES));
  assign alloc_in_pages = (32'(stack_rd) < 32'(NUM_PAGES));
  assign free_bad       = (op_page < first_page) || (LIMIT_W'(op_page) >= limit_page) ||
                          !op_in_pages;
  assign op_idx         = AW'(op_page);
  assign cur_idx        = cur[AW-1:0];

  // free rule on the count just read
  assign rel_dec    = ref_rd - REF_BITS'(1);
  assign rel_held   = (ref_rd != '0) && (rel_dec != '0);
  assign rel_push   = !rel_held && !full;
  assign rel_status = rel_held ? ST_HELD : (full ? ST_FULL : ST_OK);
  assign rel_left   = rel_held ? rel_dec : '0;
  assign inc_cnt    = (ref_rd == REF_MAX) ? ref_rd : ref_rd + REF_BITS'(1);

  assign res_load = cmd.exec || cmd.init_done;

  always_comb begin
    stack_we    = 1'b0;
    stack_waddr = depth[AW-1:0];
    stack_wdata = op_page;
    stack_re    = cmd.accept;
    stack_raddr = depth_m1[AW-1:0];
    ref_we      = 1'b0;
    ref_waddr   = op_idx;
    ref_wdata   = '0;
    ref_re      = cmd.accept;
    ref_raddr   = AW'(page);
    depth_next  = depth;
    res_status  = ST_OK;
    res_page    = '0;
    res_cnt     = '0;

    if (cmd.clr_step) begin
      ref_we    = 1'b1;
      ref_waddr = cur_idx;
    end

    if (cmd.init_rd) begin
      ref_re    = 1'b1;
      ref_raddr = cur_idx;
    end

    if (cmd.init_wr) begin
      ref_we      = (ref_rd != '0);
      ref_waddr   = cur_idx;
      ref_wdata   = rel_dec;
      stack_we    = rel_push;
      stack_wdata = cur[PAGE_W-1:0];
      if (rel_push) depth_next = depth + DW'(1);
    end

    if (cmd.init_done) begin
      res_status = init_full ? ST_FULL : ST_OK;
    end

    if (cmd.exec) begin
      case (op_cmd)
        CMD_ALLOC: begin
          if (depth == '0) begin
            res_status = ST_EMPTY;
          end else begin
            depth_next = depth_m1;
            ref_we     = alloc_in_pages;
            ref_waddr  = AW'(stack_rd);
            ref_wdata  = REF_BITS'(1);
            res_page   = stack_rd;
            res_cnt    = REF_BITS'(1);
          end
        end
        CMD_FREE: begin
          if (free_bad) begin
            res_status = ST_BAD;
          end else begin
            ref_we      = (ref_rd != '0);
            ref_wdata   = rel_dec;
            stack_we    = rel_push;
            stack_wdata = op_page;
            if (rel_push) depth_next = depth + DW'(1);
            res_status  = rel_status;
            res_cnt     = rel_left;
          end
        end
        CMD_REF_INC: begin
          if (!op_in_pages) begin
            res_status = ST_BAD;
          end else begin
            ref_we    = 1'b1;
            ref_wdata = inc_cnt;
            res_cnt   = inc_cnt;
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      cur       <= '0;
      init_full <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      depth <= depth_next;
      if (cmd.clr_step || cmd.init_wr) cur <= cur + SW'(1);
      if (cmd.accept && (command == CMD_INIT)) begin
        cur       <= SW'(first_page);
        init_full <= 1'b0;
      end
      if (cmd.init_wr && !rel_held && full) init_full <= 1'b1;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_cmd  <= command;
      op_page <= page;
      hi      <= (32'(limit_page) > 32'(NUM_PAGES)) ? SW'(NUM_PAGES) : SW'(limit_page);
    end
    if (res_load) begin
      status     <= res_status;
      alloc_page <= res_page;
      ref_count  <= CNT_W'(res_cnt);
    end
  end

  assign stat.clr_last  = (cur == SW'(NUM_PAGES - 1));
  assign stat.init_more = (cur < hi);
  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.in_init   = (command == CMD_INIT);

endmodule

// ===== rtl/core/page_allocator_with_refcount_unit.sv =====
// ----------------------------------------------------------------------------
// Page allocator with reference counts
// Usage:
//   Input channel in_valid/in_stall carries command and page; an item is
//   taken when in_valid is high and in_stall low. Every item gives exactly
//   one result (status, alloc_page, ref_count) on out_valid/out_stall.
//   Alloc, free and reference increment read the stack top and the count
//   memory when taken, then write back and load the result in S_EXEC.
//   Init walks the page range one page per S_INIT_RD and S_INIT_WR pass
//   (count read, then write and push), then loads its result.
//   One item is in work at a time; the next is taken in the cycle after the
//   previous result is loaded, while that result may still wait downstream.
//   A stalled result holds; the block takes its next item but holds it
//   before write-back until the output register frees up.
//   After rst the count memory is cleared one entry a cycle, with in_stall
//   high throughout. The APB registers first_page and limit_page must be
//   written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module page_allocator_with_refcount_unit #(
  parameter int NUM_PAGES = pga_pkg::NUM_PAGES_DEF,
  parameter int REF_BITS  = pga_pkg::REF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pga_pkg::PADDR_W-1:0]   paddr,
  input  logic [pga_pkg::APB_DW-1:0]    pwdata,
  output logic [pga_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pga_pkg::CMD_W-1:0]     command,
  input  logic [pga_pkg::PAGE_W-1:0]    page,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pga_pkg::STATUS_W-1:0]  status,
  output logic [pga_pkg::PAGE_W-1:0]    alloc_page,
  output logic [pga_pkg::CNT_W-1:0]     ref_count
);
  import pga_pkg::*;

  logic [FIRST_W-1:0] first_page;
  logic [LIMIT_W-1:0] limit_page;
  logic               reg_wr;
  logic               reg_idx;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= '0;
      limit_page <= LIMIT_RESET;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_FIRST_PAGE: first_page <= pwdata[FIRST_W-1:0];
        REG_LIMIT_PAGE: limit_page <= pwdata[LIMIT_W-1:0];
        default: begin
          first_page <= first_page;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FIRST_PAGE: prdata = APB_DW'(first_page);
      REG_LIMIT_PAGE: prdata = APB_DW'(limit_page);
      default:        prdata = '0;
    endcase
  end

  pga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  pga_dpath #(
    .NUM_PAGES (NUM_PAGES),
    .REF_BITS  (REF_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .command    (command),
    .page       (page),
    .first_page (first_page),
    .limit_page (limit_page),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .alloc_page (alloc_page),
    .ref_count  (ref_count)
  );

endmodule

// ===== rtl/core/pga_checker.sv =====
// ----------------------------------------------------------------------------
// Page allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_allocator_with_refcount_unit_defines.svh"

module pga_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pga_pkg::STATUS_W-1:0]  status,
  input logic [pga_pkg::PAGE_W-1:0]    alloc_page,
  input logic [pga_pkg::CNT_W-1:0]     ref_count
);
  import pga_pkg::*;

  logic [STATUS_W+PAGE_W+CNT_W-1:0] out_word;

  assign out_word = {status, alloc_page, ref_count};

  `PGA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `PGA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word))
  `PGA_ASSERT_IMPL(a_status_code, out_valid, status <= ST_FULL)
  `PGA_ASSERT_IMPL(a_fail_no_page, out_valid && (status != ST_OK), alloc_page == '0)
  `PGA_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

endmodule

bind page_allocator_with_refcount_unit pga_checker u_pga_checker (.*);
